/* rtl/lats_pkg.sv */
`default_nettype none
package lats_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROWS_CW = $clog2(MAX_ROWS + 1);
  localparam int COLS_CW = $clog2(MAX_COLUMNS + 1);

  localparam int CMD_W    = 2;
  localparam int ROW_FW   = 6;
  localparam int COL_FW   = 6;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = ((ROW_FW + COL_FW + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;

  localparam int CNT_MAX_W = (ROWS_CW > COLS_CW) ? ROWS_CW : COLS_CW;
  localparam int FLD_MAX_W = (ROW_FW > COL_FW) ? ROW_FW : COL_FW;
  localparam int MOD_W     = (CNT_MAX_W > FLD_MAX_W) ? CNT_MAX_W : FLD_MAX_W;

  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(10);
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(20);

  localparam logic [3:0] LIVE_MIN = 4'd2;
  localparam logic [3:0] LIVE_MAX = 4'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] value;
    logic [MOD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] result;
  } mod_rsp_t;

endpackage
`default_nettype wire

/* rtl/life_automaton_torus_step.sv */
// Toroidal B3/S23 cellular automaton held in a row-wide memory.
// Input stream: tuser carries the command (write cell, read cell, step),
// tdata carries row, column and the cell value. Every accepted item gives
// exactly one result item on the output stream: the cell for a read, 0
// otherwise. The configuration channel sets grid height and width; write
// it only while the block is idle.
// Write and read each reduce row and column modulo the grid size in the
// shared compare-subtract unit (one subtraction per cycle). A step runs
// one cell per cycle through the neighbour-count unit, plus one row write
// and one row fetch per row. One item is in work at a time; input ready
// is low until it has finished.
// Reset: a clearing pass writes every memory row dead, one row per cycle,
// with input ready low; configuration is taken.
// Output stall: a finished result waits in the output register; a further
// item may be accepted and worked, and waits for that register to empty.
`default_nettype none
module life_automaton_torus_step (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // row [5:0], column [11:6], cell_in [12], zero [15:13]
  input  wire logic [lats_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // command [1:0]
  input  wire logic [lats_pkg::CMD_W-1:0]           s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // cell_out [0], zero [7:1]
  output logic      [lats_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [lats_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [lats_pkg::CFG_W-1:0]           cfg_data_i
);
  import lats_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD_ROW,
    ST_MOD_COL,
    ST_ACC_RD,
    ST_ACC,
    ST_RD_UP,
    ST_RD_MID,
    ST_RD_DN,
    ST_LD_DN,
    ST_CELL,
    ST_WR,
    ST_PUSH
  } state_e;

  state_e                 state_q, state_d;
  logic [ROW_W-1:0]       clr_q, clr_d;
  cmd_e                   cmd_q, cmd_d;
  logic                   cell_q, cell_d;
  logic [COL_FW-1:0]      col_q, col_d;
  logic [ROW_W-1:0]       r_q, r_d;
  logic [COL_W-1:0]       c_q, c_d;
  logic [ROW_W-1:0]       y_q, y_d;
  logic [COL_W-1:0]       x_q, x_d;
  logic [MAX_COLUMNS-1:0] up_q, up_d;
  logic [MAX_COLUMNS-1:0] mid_q, mid_d;
  logic [MAX_COLUMNS-1:0] dn_q, dn_d;
  logic [MAX_COLUMNS-1:0] row0_q, row0_d;
  logic [MAX_COLUMNS-1:0] new_q, new_d;
  logic                   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_data_q, out_data_d;
  logic [CFG_W-1:0]       h_cfg_q;
  logic [CFG_W-1:0]       w_cfg_q;

  logic [ROWS_CW-1:0]     h_act;
  logic [COLS_CW-1:0]     w_act;
  logic                   in_acc;
  logic                   cell_next;
  logic [MAX_COLUMNS-1:0] wr_row;

  logic                   ram_we;
  logic [ROW_W-1:0]       ram_waddr;
  logic [MAX_COLUMNS-1:0] ram_wdata;
  logic [ROW_W-1:0]       ram_raddr;
  logic [MAX_COLUMNS-1:0] ram_rdata;

  mod_req_t               mod_req;
  mod_rsp_t               mod_rsp;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_data_q};
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    if (h_cfg_q == '0) begin
      h_act = ROWS_CW'(1);
    end else if (32'(h_cfg_q) > MAX_ROWS) begin
      h_act = ROWS_CW'(MAX_ROWS);
    end else begin
      h_act = ROWS_CW'(h_cfg_q);
    end
    if (w_cfg_q == '0) begin
      w_act = COLS_CW'(1);
    end else if (32'(w_cfg_q) > MAX_COLUMNS) begin
      w_act = COLS_CW'(MAX_COLUMNS);
    end else begin
      w_act = COLS_CW'(w_cfg_q);
    end
  end

  lats_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lats_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  lats_cell_unit u_cell (
    .up_i   (up_q),
    .mid_i  (mid_q),
    .dn_i   (dn_q),
    .x_i    (x_q),
    .w_i    (w_act),
    .next_o (cell_next)
  );

  always_comb begin
    wr_row      = ram_rdata;
    wr_row[c_q] = cell_q;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    cell_d      = cell_q;
    col_d       = col_q;
    r_d         = r_q;
    c_d         = c_q;
    y_d         = y_q;
    x_d         = x_q;
    up_d        = up_q;
    mid_d       = mid_q;
    dn_d        = dn_q;
    row0_d      = row0_q;
    new_d       = new_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    ram_we      = 1'b0;
    ram_waddr   = y_q;
    ram_wdata   = new_q;
    ram_raddr   = '0;

    mod_req.start   = 1'b0;
    mod_req.value   = MOD_W'(col_q);
    mod_req.divisor = MOD_W'(w_act);

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ROW_W'(1);
        if (clr_q == ROW_W'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d  = cmd_e'(s_axis_tuser);
          col_d  = s_axis_tdata[ROW_FW +: COL_FW];
          cell_d = s_axis_tdata[ROW_FW + COL_FW];
          res_d  = 1'b0;
          case (cmd_e'(s_axis_tuser))
            CMD_WRITE, CMD_READ: begin
              mod_req.start   = 1'b1;
              mod_req.value   = MOD_W'(s_axis_tdata[ROW_FW-1:0]);
              mod_req.divisor = MOD_W'(h_act);
              state_d         = ST_MOD_ROW;
            end
            CMD_STEP: begin
              state_d = ST_RD_UP;
            end
            default: begin
              state_d = ST_PUSH;
            end
          endcase
        end
      end
      ST_MOD_ROW: begin
        if (mod_rsp.done) begin
          r_d           = ROW_W'(mod_rsp.result);
          mod_req.start = 1'b1;
          state_d       = ST_MOD_COL;
        end
      end
      ST_MOD_COL: begin
        if (mod_rsp.done) begin
          c_d     = COL_W'(mod_rsp.result);
          state_d = ST_ACC_RD;
        end
      end
      ST_ACC_RD: begin
        ram_raddr = r_q;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        if (cmd_q == CMD_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = r_q;
          ram_wdata = wr_row;
        end else begin
          res_d = ram_rdata[c_q];
        end
        state_d = ST_PUSH;
      end
      ST_RD_UP: begin
        ram_raddr = ROW_W'(h_act - ROWS_CW'(1));
        y_d       = '0;
        state_d   = ST_RD_MID;
      end
      ST_RD_MID: begin
        up_d      = ram_rdata;
        ram_raddr = '0;
        state_d   = ST_RD_DN;
      end
      ST_RD_DN: begin
        mid_d     = ram_rdata;
        row0_d    = ram_rdata;
        ram_raddr = y_q + ROW_W'(1);
        state_d   = ST_LD_DN;
      end
      ST_LD_DN: begin
        // wrap to the saved first row, since memory row 0 may already hold the new generation
        if ((ROWS_CW'(y_q) + ROWS_CW'(1)) == h_act) begin
          dn_d = row0_q;
        end else begin
          dn_d = ram_rdata;
        end
        new_d   = mid_q;
        x_d     = '0;
        state_d = ST_CELL;
      end
      ST_CELL: begin
        new_d[x_q] = cell_next;
        x_d        = x_q + COL_W'(1);
        if ((COLS_CW'(x_q) + COLS_CW'(1)) == w_act) begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = y_q;
        ram_wdata = new_q;
        if ((ROWS_CW'(y_q) + ROWS_CW'(1)) == h_act) begin
          state_d = ST_PUSH;
        end else begin
          up_d      = mid_q;
          mid_d     = dn_q;
          y_d       = y_q + ROW_W'(1);
          ram_raddr = y_q + ROW_W'(2);
          state_d   = ST_LD_DN;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cmd_q       <= CMD_WRITE;
      r_q         <= '0;
      c_q         <= '0;
      y_q         <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
      h_cfg_q     <= HEIGHT_RESET;
      w_cfg_q     <= WIDTH_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cmd_q       <= cmd_d;
      r_q         <= r_d;
      c_q         <= c_d;
      y_q         <= y_d;
      x_q         <= x_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GRID_HEIGHT) begin
          h_cfg_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_GRID_WIDTH) begin
          w_cfg_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q     <= cell_d;
    col_q      <= col_d;
    up_q       <= up_d;
    mid_q      <= mid_d;
    dn_q       <= dn_d;
    row0_q     <= row0_d;
    new_q      <= new_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

endmodule
`default_nettype wire

/* rtl/lats_ram.sv */
`default_nettype none
module lats_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/lats_mod.sv */
`default_nettype none
module lats_mod (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lats_pkg::mod_req_t req_i,
  output lats_pkg::mod_rsp_t      rsp_o
);
  import lats_pkg::*;

  logic             busy_q;
  logic [MOD_W-1:0] rem_q;
  logic [MOD_W-1:0] div_q;

  assign rsp_o.done   = busy_q && (rem_q < div_q);
  assign rsp_o.result = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      div_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      rem_q  <= req_i.value;
      div_q  <= req_i.divisor;
    end else if (busy_q) begin
      if (rem_q >= div_q) begin
        rem_q <= rem_q - div_q;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/lats_cell_unit.sv */
`default_nettype none
module lats_cell_unit (
  input  wire logic [lats_pkg::MAX_COLUMNS-1:0] up_i,
  input  wire logic [lats_pkg::MAX_COLUMNS-1:0] mid_i,
  input  wire logic [lats_pkg::MAX_COLUMNS-1:0] dn_i,
  input  wire logic [lats_pkg::COL_W-1:0]       x_i,
  input  wire logic [lats_pkg::COLS_CW-1:0]     w_i,
  output logic                                  next_o
);
  import lats_pkg::*;

  logic [COL_W-1:0] lf;
  logic [COL_W-1:0] rt;
  logic [7:0]       nbr;
  logic [3:0]       n;
  logic             alive;

  always_comb begin
    lf = (x_i == '0) ? COL_W'(w_i - COLS_CW'(1)) : x_i - COL_W'(1);
    rt = ((COLS_CW'(x_i) + COLS_CW'(1)) == w_i) ? '0 : x_i + COL_W'(1);
    nbr = {up_i[lf], up_i[x_i], up_i[rt], mid_i[lf], mid_i[rt],
           dn_i[lf], dn_i[x_i], dn_i[rt]};
    alive = mid_i[x_i];
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nbr[i]);
    end
    next_o = (n == LIVE_MAX) || (alive && (n == LIVE_MIN));
  end

endmodule
`default_nettype wire

/* tb/life_automaton_torus_step_test.sv */
`default_nettype none
module life_automaton_torus_step_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lats_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT        = 19;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 2_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]      cfg_data_i;

  logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
  logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
  bit               life_grid [MAX_ROWS][MAX_COLUMNS];
  bit               next_grid [MAX_ROWS][MAX_COLUMNS];
  bit               cell_out_due [$];
  bit               due_cell;
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               hold_left = 0;
  logic             hold_req;
  bit               gaps_off = 1'b0;

  life_automaton_torus_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned span(logic [CFG_W-1:0] reg_value, int unsigned limit);
    if (reg_value == '0) return 1;
    if (reg_value > limit) return limit;
    return reg_value;
  endfunction

  function automatic bit apply_cell_command(logic [CMD_W-1:0] cmd, logic [ROW_FW-1:0] row,
                                            logic [COL_FW-1:0] col, logic cell_in);
    int unsigned h, w, r, c, up, dn, lf, rt, n;
    h = span(height_reg, MAX_ROWS);
    w = span(width_reg, MAX_COLUMNS);
    r = row % h;
    c = col % w;
    apply_cell_command = 1'b0;
    case (cmd)
      CMD_WRITE: life_grid[r][c] = cell_in;
      CMD_READ:  apply_cell_command = life_grid[r][c];
      CMD_STEP: begin
        next_grid = life_grid;
        for (int unsigned y = 0; y < h; y++) begin
          up = (y + h - 1) % h;
          dn = (y + 1) % h;
          for (int unsigned x = 0; x < w; x++) begin
            lf = (x + w - 1) % w;
            rt = (x + 1) % w;
            n = life_grid[up][lf] + life_grid[up][x] + life_grid[up][rt]
              + life_grid[y][lf] + life_grid[y][rt]
              + life_grid[dn][lf] + life_grid[dn][x] + life_grid[dn][rt];
            next_grid[y][x] = (n == 3) || (life_grid[y][x] && n == 2);
          end
        end
        life_grid = next_grid;
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_cell_item(logic [CMD_W-1:0] cmd, logic [ROW_FW-1:0] row,
                                logic [COL_FW-1:0] col, logic cell_in);
    if (!gaps_off && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({cell_in, col, row});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    cell_out_due.push_back(apply_cell_command(cmd, row, col, cell_in));
  endtask

  task automatic send_noise_item();
    send_cell_item(CMD_W'($urandom_range(3)), ROW_FW'($urandom), COL_FW'($urandom),
                   1'($urandom));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (cell_out_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    drain_results();
    repeat (16) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == CFG_GRID_HEIGHT) height_reg = value;
    else width_reg = value;
  endtask

  task automatic set_grid(logic [CFG_W-1:0] h, logic [CFG_W-1:0] w);
    write_size_reg(CFG_GRID_HEIGHT, h);
    write_size_reg(CFG_GRID_WIDTH, w);
  endtask

  task automatic run_generation_round(logic [CFG_W-1:0] h, logic [CFG_W-1:0] w,
                                      int writes, int steps, int reads);
    set_grid(h, w);
    repeat (writes)
      send_cell_item(CMD_WRITE, ROW_FW'($urandom), COL_FW'($urandom),
                     $urandom_range(99) < 60);
    repeat (steps) begin
      send_cell_item(CMD_STEP, ROW_FW'($urandom), COL_FW'($urandom), 1'($urandom));
      if ($urandom_range(99) < 30) send_noise_item();
    end
    repeat (reads)
      send_cell_item(CMD_READ, ROW_FW'($urandom), COL_FW'($urandom), 1'($urandom));
  endtask

  task automatic test_reset_and_blinker();
    send_cell_item(CMD_READ, 6'd0, 6'd0, 1'b0);
    send_cell_item(CMD_READ, 6'd63, 6'd63, 1'b1);
    send_cell_item(CMD_WRITE, 6'd63, 6'd63, 1'b1);
    send_cell_item(CMD_READ, 6'd3, 6'd3, 1'b0);
    send_cell_item(CMD_WRITE, 6'd5, 6'd4, 1'b1);
    send_cell_item(CMD_WRITE, 6'd5, 6'd5, 1'b1);
    send_cell_item(CMD_WRITE, 6'd5, 6'd6, 1'b1);
    send_cell_item(CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_cell_item(CMD_READ, 6'd4, 6'd5, 1'b0);
    send_cell_item(CMD_READ, 6'd5, 6'd4, 1'b0);
    send_cell_item(CMD_UNUSED, 6'd5, 6'd5, 1'b1);
    send_cell_item(CMD_READ, 6'd5, 6'd5, 1'b0);
  endtask

  task automatic test_size_extremes();
    set_grid(7'd0, 7'd0);
    send_cell_item(CMD_WRITE, 6'd63, 6'd63, 1'b1);
    send_cell_item(CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_cell_item(CMD_READ, 6'd0, 6'd0, 1'b0);
    set_grid(7'd127, 7'd64);
    send_cell_item(CMD_STEP, 6'd63, 6'd63, 1'b1);
    send_cell_item(CMD_WRITE, 6'd40, 6'd50, 1'b1);
    set_grid(7'd3, 7'd3);
    send_cell_item(CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_cell_item(CMD_READ, 6'd2, 6'd2, 1'b0);
    set_grid(7'd64, 7'd64);
    send_cell_item(CMD_READ, 6'd40, 6'd50, 1'b0);
  endtask

  task automatic test_random_generations();
    repeat (3)
      run_generation_round(7'($urandom_range(9, 3)), 7'($urandom_range(9, 3)), 8, 2, 8);
    run_generation_round(7'($urandom_range(2, 1)), 7'($urandom_range(5, 1)), 5, 2, 5);
    run_generation_round(7'($urandom_range(4, 0)), 7'($urandom_range(2, 0)), 5, 2, 5);
    run_generation_round(7'($urandom_range(127, 65)), 7'($urandom_range(127, 40)), 6, 1, 6);
  endtask

  task automatic test_output_hold_off();
    set_grid(7'd5, 7'd5);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    repeat (15)
      send_cell_item($urandom_range(1) ? CMD_READ : CMD_WRITE, ROW_FW'($urandom),
                     COL_FW'($urandom), 1'($urandom));
  endtask

  task automatic test_steady_stream();
    set_grid(7'd6, 7'd7);
    gaps_off = 1'b1;
    repeat (20) begin
      if ($urandom_range(99) < 15) send_noise_item();
      else send_cell_item($urandom_range(1) ? CMD_READ : CMD_WRITE, ROW_FW'($urandom),
                          COL_FW'($urandom), 1'($urandom));
    end
    drain_results();
    gaps_off = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_req) hold_left <= HOLD_OFF_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    if (hold_req || hold_left > 1) m_axis_tready <= 1'b0;
    else m_axis_tready <= gaps_off || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cell_out_due.size() == 0) begin
        flag_mismatch("result item with nothing due");
      end else begin
        due_cell = cell_out_due.pop_front();
        if (m_axis_tdata[0] !== due_cell)
          flag_mismatch($sformatf("cell_out %b, due %b", m_axis_tdata[0], due_cell));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("life_automaton_torus_step_test NOT OK");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    hold_req      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_and_blinker();
    test_size_extremes();
    test_random_generations();
    test_output_hold_off();
    test_steady_stream();
    drain_results();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("life_automaton_torus_step_test OK");
    end else begin
      $display("life_automaton_torus_step_test NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/lats_pkg.sv
rtl/lats_ram.sv
rtl/lats_mod.sv
rtl/lats_cell_unit.sv
rtl/life_automaton_torus_step.sv
tb/life_automaton_torus_step_test.sv
